FILE: hdl/mctc_pkg.sv
package mctc_pkg;

    localparam int unsigned SETS_DEFAULT = 64;
    localparam int unsigned WAYS_DEFAULT = 4;
    localparam int unsigned TAG_W = 30;
    localparam int unsigned STAMP_W = 32;
    localparam logic [3:0] LINE_BITS_RESET = 4'd6;
    localparam logic [2:0] SET_BITS_RESET = 3'd6;

    localparam logic [1:0] OP_CPU = 2'd0;
    localparam logic [1:0] OP_SNOOP = 2'd1;
    localparam logic [1:0] OP_FILL = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    localparam logic [1:0] SN_RD = 2'd0;
    localparam logic [1:0] SN_RDX = 2'd1;
    localparam logic [1:0] SN_WINV = 2'd2;
    localparam logic [1:0] SN_KEEP = 2'd3;

    localparam logic [1:0] BR_NONE = 2'd0;
    localparam logic [1:0] BR_RD = 2'd1;
    localparam logic [1:0] BR_RDX = 2'd2;
    localparam logic [1:0] BR_WINV = 2'd3;

    localparam logic CFG_LINE_BITS = 1'b0;
    localparam logic CFG_SET_BITS = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [TAG_W-1:0] tag;
        logic [11:0] set;
        logic is_write;
        logic [1:0] snoop_kind;
        logic [1:0] fill_state;
    } t_req;

    typedef struct packed {
        logic hit;
        logic [1:0] prior_state;
        logic [1:0] bus_request;
        logic victim_valid;
        logic [1:0] victim_state;
        logic [TAG_W-1:0] victim_tag;
        logic needs_writeback;
    } t_res;

endpackage

FILE: hdl/mctc_front.sv
`default_nettype none
module mctc_front
    import mctc_pkg::*;
#(
    parameter int unsigned SETS = SETS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_address,
    input  wire logic        i_is_write,
    input  wire logic [1:0]  i_snoop_kind,
    input  wire logic [1:0]  i_fill_state,
    output logic             o_q_valid,
    output t_req             o_q_req,
    input  wire logic        i_q_pop
);
    localparam logic [3:0] MAX_SB = 4'($clog2(SETS + 1) - 1);

    logic [3:0] r_line_bits;
    logic [2:0] r_set_bits;
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    t_req       r_q [2];
    t_req       w_req;
    logic [3:0] w_sh, w_sb;
    logic [31:0] w_tag32;
    logic [11:0] w_mask;
    logic       w_push;

    assign o_cfg_ready = 1'b1;
    assign o_busy = (r_cnt == 2'd2);
    assign w_push = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req = r_q[r_rp];

    always_comb begin
        w_sh = (r_line_bits < 4'd2) ? 4'd2 : r_line_bits;
        w_sb = ({1'b0, r_set_bits} > MAX_SB) ? MAX_SB : {1'b0, r_set_bits};
        w_tag32 = i_address >> w_sh;
        w_mask = 12'((13'd1 << w_sb) - 13'd1);
        w_req.op = i_op;
        w_req.tag = w_tag32[TAG_W-1:0];
        w_req.set = w_tag32[11:0] & w_mask;
        w_req.is_write = i_is_write;
        w_req.snoop_kind = i_snoop_kind;
        w_req.fill_state = i_fill_state;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bits <= LINE_BITS_RESET;
            r_set_bits <= SET_BITS_RESET;
            r_cnt <= 2'd0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LINE_BITS: r_line_bits <= i_cfg_data;
                    CFG_SET_BITS: r_set_bits <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            r_cnt <= n_cnt;
            if (w_push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_req;
    end
endmodule
`default_nettype wire

FILE: hdl/mctc_back.sv
`default_nettype none
module mctc_back
    import mctc_pkg::*;
#(
    parameter int unsigned SETS = SETS_DEFAULT,
    parameter int unsigned WAYS = WAYS_DEFAULT,
    parameter int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1,
    parameter int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  t_req      i_q_req,
    output logic      o_q_pop,
    output logic      o_done,
    output t_res      o_res
);
    localparam int unsigned ROWS = 1 << SET_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state;
    t_req   r_req;
    logic [ROWS-1:0] r_row_valid;
    logic [WAYS*TAG_W-1:0]   r_tag_mem [ROWS];
    logic [WAYS*2-1:0]       r_st_mem [ROWS];
    logic [WAYS*STAMP_W-1:0] r_stp_mem [ROWS];
    logic [WAYS*TAG_W-1:0]   r_tags;
    logic [WAYS*2-1:0]       r_sts;
    logic [WAYS*STAMP_W-1:0] r_stps;
    logic [STAMP_W-1:0] r_stamp;
    t_res r_res;
    logic r_done;

    logic [WAYS*TAG_W-1:0]   n_tags;
    logic [WAYS*2-1:0]       n_sts;
    logic [WAYS*STAMP_W-1:0] n_stps;
    logic [STAMP_W-1:0] n_stamp;
    t_res n_res;
    logic [SET_W-1:0] w_set;
    logic [WAYS*2-1:0] w_sts;
    logic [WAY_W-1:0] w_way, w_pick;
    logic w_found, w_inv_found;
    logic [STAMP_W-1:0] w_old;
    logic [1:0] w_st;

    assign w_set = r_req.set[SET_W-1:0];
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_done = r_done;
    assign o_res = r_res;
    assign w_sts = r_row_valid[w_set] ? r_sts : '0;

    always_comb begin
        w_found = 1'b0;
        w_way = '0;
        w_inv_found = 1'b0;
        w_pick = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!w_found && w_sts[w*2 +: 2] != ST_I &&
                r_tags[w*TAG_W +: TAG_W] == r_req.tag) begin
                w_found = 1'b1;
                w_way = WAY_W'(w);
            end
            if (!w_inv_found && w_sts[w*2 +: 2] == ST_I) begin
                w_inv_found = 1'b1;
                w_pick = WAY_W'(w);
            end
        end
        w_old = r_stps[STAMP_W-1:0];
        if (!w_inv_found) begin
            for (int w = 1; w < WAYS; w++) begin
                if (r_stps[w*STAMP_W +: STAMP_W] < w_old) begin
                    w_old = r_stps[w*STAMP_W +: STAMP_W];
                    w_pick = WAY_W'(w);
                end
            end
        end
        n_tags = r_row_valid[w_set] ? r_tags : '0;
        n_sts = w_sts;
        n_stps = r_row_valid[w_set] ? r_stps : '0;
        n_stamp = r_stamp;
        n_res = '0;
        w_st = w_sts[w_way*2 +: 2];
        case (r_req.op)
            OP_CPU: begin
                if (r_stamp != '1) n_stamp = r_stamp + 1'b1;
                if (w_found) begin
                    n_stps[w_way*STAMP_W +: STAMP_W] = n_stamp;
                    n_res.hit = 1'b1;
                    n_res.prior_state = w_st;
                    if (r_req.is_write) begin
                        if (w_st == ST_S) n_res.bus_request = BR_WINV;
                        n_sts[w_way*2 +: 2] = ST_M;
                    end
                end else begin
                    n_res.bus_request = r_req.is_write ? BR_RDX : BR_RD;
                end
            end
            OP_SNOOP: begin
                if (w_found) begin
                    n_res.hit = 1'b1;
                    n_res.prior_state = w_st;
                    if (r_req.snoop_kind == SN_RD) n_sts[w_way*2 +: 2] = ST_S;
                    else if (r_req.snoop_kind == SN_RDX || r_req.snoop_kind == SN_WINV)
                        n_sts[w_way*2 +: 2] = ST_I;
                end
            end
            OP_FILL: begin
                if (r_req.fill_state != ST_I) begin
                    if (!w_inv_found) begin
                        n_res.victim_valid = 1'b1;
                        n_res.victim_state = w_sts[w_pick*2 +: 2];
                        n_res.victim_tag = n_tags[w_pick*TAG_W +: TAG_W];
                        n_res.needs_writeback = (w_sts[w_pick*2 +: 2] == ST_M);
                    end
                    n_tags[w_pick*TAG_W +: TAG_W] = r_req.tag;
                    n_sts[w_pick*2 +: 2] = r_req.fill_state;
                    n_stps[w_pick*STAMP_W +: STAMP_W] = r_stamp;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row_valid <= '0;
            r_stamp <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_q_valid) r_state <= S_LOOK;
                S_LOOK: begin
                    r_state <= S_IDLE;
                    r_done <= 1'b1;
                    r_stamp <= n_stamp;
                    r_row_valid[w_set] <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req <= i_q_req;
            r_tags <= r_tag_mem[i_q_req.set[SET_W-1:0]];
            r_sts <= r_st_mem[i_q_req.set[SET_W-1:0]];
            r_stps <= r_stp_mem[i_q_req.set[SET_W-1:0]];
        end
        if (r_state == S_LOOK) begin
            r_tag_mem[w_set] <= n_tags;
            r_st_mem[w_set] <= n_sts;
            r_stp_mem[w_set] <= n_stps;
            r_res <= n_res;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/mesi_cache_tag_controller.sv
// MESI tag and state store of a snooping cache with timestamp LRU. Requests
// are taken while busy is low and pass through a two-entry queue to the
// lookup engine, which handles each request in two steps (set read from tag
// memory, then compare and write back) and takes the next one from the queue
// only when it is done with the last. Each result is shown for one cycle with
// o_done and cannot be held off by the receiver.
// Reset clears sets through per-set valid bits; no clearing pass is needed.
`default_nettype none
module mesi_cache_tag_controller
    import mctc_pkg::*;
#(
    parameter int unsigned SETS = SETS_DEFAULT,
    parameter int unsigned WAYS = WAYS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_address,
    input  wire logic        i_is_write,
    input  wire logic [1:0]  i_snoop_kind,
    input  wire logic [1:0]  i_fill_state,
    output logic             o_done,
    output logic             o_hit,
    output logic [1:0]       o_prior_state,
    output logic [1:0]       o_bus_request,
    output logic             o_victim_valid,
    output logic [1:0]       o_victim_state,
    output logic [29:0]      o_victim_tag,
    output logic             o_needs_writeback
);
    t_req w_req;
    t_res w_res;
    logic w_qv, w_pop;

    mctc_front #(.SETS(SETS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_start(start), .o_busy(busy), .i_op, .i_address, .i_is_write,
        .i_snoop_kind, .i_fill_state,
        .o_q_valid(w_qv), .o_q_req(w_req), .i_q_pop(w_pop)
    );

    mctc_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_req(w_req), .o_q_pop(w_pop),
        .o_done, .o_res(w_res)
    );

    assign o_hit = w_res.hit;
    assign o_prior_state = w_res.prior_state;
    assign o_bus_request = w_res.bus_request;
    assign o_victim_valid = w_res.victim_valid;
    assign o_victim_state = w_res.victim_state;
    assign o_victim_tag = w_res.victim_tag;
    assign o_needs_writeback = w_res.needs_writeback;
endmodule
`default_nettype wire
